// ===== design/psfc_pkg.sv =====
// Package for the palette store with format conversion.
// Holds the item types, format and status codes, and the pack and unpack functions.
// Depends on nothing.
package psfc_pkg;

	localparam int PALETTE_DEPTH_DEF = 256;
	localparam int CFG_DATA_W        = 9;
	localparam int CFG_INDEX_W       = 1;

	typedef enum logic [2:0] {
		FMT_XRGB1555 = 3'd0,
		FMT_ARGB1555 = 3'd1,
		FMT_ARGB4444 = 3'd2,
		FMT_RGBA8888 = 3'd3,
		FMT_BGRA8888 = 3'd4
	} fmt_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADFMT = 2'd1,
		ST_RANGE  = 2'd2
	} status_t;

	typedef enum logic {
		REQ_WRITE = 1'b0,
		REQ_READ  = 1'b1
	} req_type_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PIXEL_FORMAT = 1'b0,
		REG_COLOR_COUNT  = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic [7:0] in_alpha;
		logic [7:0] in_blue;
		logic [7:0] in_green;
		logic [7:0] in_red;
		logic [7:0] entry_index;
		logic       req_type;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] out_alpha;
		logic [7:0] out_blue;
		logic [7:0] out_green;
		logic [7:0] out_red;
	} rsp_t;

	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rgba_t;

	// Pack an 8-bit color into a palette word. Its result is used only for a writable format.
	function automatic logic [31:0] pack_color(input rgba_t c, input logic [2:0] fmt);
		logic [31:0] w;
		w = '0;
		case (fmt)
			FMT_XRGB1555: w = {17'd0, c.blue[7:3], c.green[7:3], c.red[7:3]};
			FMT_ARGB1555: w = {16'd0, c.alpha[7], c.blue[7:3], c.green[7:3], c.red[7:3]};
			FMT_ARGB4444: w = {16'd0, c.alpha[7:4], c.blue[7:4], c.green[7:4], c.red[7:4]};
			FMT_RGBA8888: w = {c.alpha, c.blue, c.green, c.red};
			default:      w = {c.alpha, c.red, c.green, c.blue};
		endcase
		return w;
	endfunction

	// Unpack a palette word: 1555/4444 fields top-align, low bits zero; 8888 is copied.
	function automatic rgba_t unpack_color(input logic [31:0] w, input logic [2:0] fmt);
		rgba_t c;
		c = '0;
		case (fmt)
			FMT_XRGB1555, FMT_ARGB1555: begin
				c.red   = {w[4:0], 3'd0};
				c.green = {w[9:5], 3'd0};
				c.blue  = {w[14:10], 3'd0};
				c.alpha = (fmt == FMT_ARGB1555 && !w[15]) ? 8'd0 : 8'hFF;
			end
			FMT_ARGB4444: begin
				c.red   = {w[3:0], 4'd0};
				c.green = {w[7:4], 4'd0};
				c.blue  = {w[11:8], 4'd0};
				c.alpha = {w[15:12], 4'd0};
			end
			default: begin
				c = rgba_t'(w);
			end
		endcase
		return c;
	endfunction

endpackage

// ===== design/palette_store_format_convert_unit.sv =====
// Top level of the palette store with format conversion: palette memory,
// request pipeline and output register. Depends on psfc_pkg.

// How the block is used:
// Requests arrive on the req channel (req_valid, req_stall, req). Each item
// either writes one palette entry, packing its 8-bit RGBA color into the
// configured pixel format, or reads one entry and unpacks it back to RGBA.
// Every item yields exactly one result item on the rsp channel (rsp_valid,
// rsp_stall, rsp) carrying the color read and a status code.
// The palette memory is read at the accepting edge, its registered data is
// unpacked in the middle stage, and the result then lands in the output
// register once that register is free or being emptied.
// Throughput is one item per cycle while the receiver does not stall, set by
// the single port pair of the palette memory; writes land in memory at the
// accepting edge, so a read right behind a write to the same entry already
// sees the new word.
// When the receiver stalls, the result holds in the output register, the
// middle stage still fills, and req_stall rises only once both are full.
// Reset clears the pipeline valid bits and sets the pixel format to RGBA8888
// and the color count to zero; the palette memory itself is not cleared, so
// an entry must be written before it is read.
// The user must write the configuration port (cfg_we, cfg_index, cfg_data)
// only while the block is idle; the block itself does not enforce this.
module palette_store_format_convert_unit #(
	parameter int PALETTE_DEPTH = psfc_pkg::PALETTE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [psfc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [psfc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  psfc_pkg::req_t                      req,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output psfc_pkg::rsp_t                      rsp
);
	import psfc_pkg::*;

	localparam int ADDR_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

	// Configuration registers.
	logic [2:0] pixel_format_q;
	logic [8:0] color_count_q;

	// Palette memory, one write and one registered read per cycle.
	logic [31:0] palette_mem [PALETTE_DEPTH];

	logic              accept;
	logic              advance;
	logic [31:0]       idx_ext;
	logic [ADDR_W-1:0] addr;
	logic              in_range;
	logic [1:0]        status_in;
	logic              mem_we;
	logic              mem_re;
	logic [31:0]       wr_word;

	// Middle stage: the request details beside the registered memory data.
	logic              valid_s1;
	logic              is_read_s1;
	logic [2:0]        fmt_s1;
	logic [1:0]        status_s1;
	logic [31:0]       rd_data_s1;

	rgba_t             color_s1;
	rsp_t              rsp_next;

	logic              rsp_valid_q;
	rsp_t              rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_format_q <= FMT_RGBA8888;
			color_count_q  <= '0;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_PIXEL_FORMAT: pixel_format_q <= cfg_data[2:0];
				REG_COLOR_COUNT:  color_count_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Flow control: the middle stage moves on when the output register is free.
	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;
	assign accept    = req_valid && !req_stall;

	assign idx_ext  = 32'(req.entry_index);
	assign addr     = idx_ext[ADDR_W-1:0];
	assign in_range = ({1'b0, req.entry_index} < color_count_q) &&
		(idx_ext < 32'(PALETTE_DEPTH));

	always_comb begin
		if (!in_range) begin
			status_in = ST_RANGE;
		end else if (req.req_type == REQ_READ) begin
			status_in = (pixel_format_q <= FMT_RGBA8888) ? ST_OK : ST_BADFMT;
		end else begin
			status_in = (pixel_format_q <= FMT_BGRA8888) ? ST_OK : ST_BADFMT;
		end
	end

	assign mem_we  = accept && (req.req_type == REQ_WRITE) && (status_in == ST_OK);
	assign mem_re  = accept && (req.req_type == REQ_READ) && (status_in == ST_OK);
	assign wr_word = pack_color({req.in_alpha, req.in_blue, req.in_green, req.in_red},
		pixel_format_q);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			palette_mem[addr] <= wr_word;
		end
		if (mem_re) begin
			rd_data_s1 <= palette_mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			is_read_s1 <= (req.req_type == REQ_READ);
			fmt_s1     <= pixel_format_q;
			status_s1  <= status_in;
		end
	end

	// Colors are only reported for good reads; writes and errors give zeros.
	always_comb begin
		color_s1 = unpack_color(rd_data_s1, fmt_s1);
		rsp_next = '0;
		rsp_next.status = status_s1;
		if (is_read_s1 && status_s1 == ST_OK) begin
			rsp_next.out_red   = color_s1.red;
			rsp_next.out_green = color_s1.green;
			rsp_next.out_blue  = color_s1.blue;
			rsp_next.out_alpha = color_s1.alpha;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// An accepted item always occupies the middle stage on the next cycle.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted item did not reach the middle stage");

	// A held middle stage keeps its memory data until it can move on.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(rd_data_s1) && $stable(status_s1)))
		else $error("middle stage changed while held");

	// A waiting result is not overwritten while the receiver stalls.
	a_out_not_overwritten: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_stall) |-> !advance)
		else $error("output register overwritten under stall");

	// Writes and failed accesses report no color.
	a_zero_color: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (!is_read_s1 || status_s1 != ST_OK)) |=>
		(rsp_q.out_red == 8'd0 && rsp_q.out_green == 8'd0 &&
		rsp_q.out_blue == 8'd0 && rsp_q.out_alpha == 8'd0))
		else $error("color reported for a write or an error");

	// The memory is touched only by an item that passed the range check.
	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ({1'b0, req.entry_index} < color_count_q))
		else $error("palette write outside the color count");

endmodule
